// File: src/trse_pkg.sv
// Package for the typed RPN stack evaluator: action and status codes,
// default sizes and the command and status structs. No dependencies.
package trse_pkg;

	localparam int DefStackDepth = 64;
	localparam int DefWordBits   = 32;

	localparam logic [4:0] ACT_PUSH_INT  = 5'd0;
	localparam logic [4:0] ACT_PUSH_BOOL = 5'd1;
	localparam logic [4:0] ACT_NOT       = 5'd2;
	localparam logic [4:0] ACT_DUP       = 5'd3;
	localparam logic [4:0] ACT_DROP      = 5'd4;
	localparam logic [4:0] ACT_CLEAR     = 5'd5;
	localparam logic [4:0] ACT_SWAP      = 5'd6;
	localparam logic [4:0] ACT_ADD       = 5'd7;
	localparam logic [4:0] ACT_SUB       = 5'd8;
	localparam logic [4:0] ACT_MUL       = 5'd9;
	localparam logic [4:0] ACT_DIV       = 5'd10;
	localparam logic [4:0] ACT_MOD       = 5'd11;
	localparam logic [4:0] ACT_EQ        = 5'd12;
	localparam logic [4:0] ACT_LT        = 5'd13;
	localparam logic [4:0] ACT_GT        = 5'd14;
	localparam logic [4:0] ACT_LE        = 5'd15;
	localparam logic [4:0] ACT_GE        = 5'd16;
	localparam logic [4:0] ACT_PRINT     = 5'd17;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_NOT_BOOL = 3'd2;
	localparam logic [2:0] ST_NOT_INT  = 3'd3;
	localparam logic [2:0] ST_DIV_ZERO = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;   // capture action and push value
		logic rd_top;     // load the A register from the read of sp-1, address sp-2
		logic rd_next;    // load the B register from the read of sp-2
		logic pop_one;    // sp -= 1
		logic pop_two;    // sp -= 2
		logic clear;      // sp = 0
		logic wr_push;    // write result at sp, sp += 1
		logic wr_top;     // overwrite entry at sp-1 with result
		logic wr_swap;    // write A at sp, sp += 1, and move B into A
		logic div_start;  // start the divider
		logic mul_cap;    // register the product
		logic done;       // present the result word
	} trse_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_busy;
	} trse_sts_t;

endpackage

// File: src/trse_div.sv
// Iterative signed divider, one quotient bit per cycle.
// Depends on nothing but its parameter.
module trse_div #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] dividend,
	input  logic [WORD_BITS-1:0] divisor,
	output logic                 busy,
	output logic [WORD_BITS-1:0] quotient,
	output logic [WORD_BITS-1:0] remainder
);
	localparam int CW = $clog2(WORD_BITS + 1);

	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS-1:0] q_q, r_q, d_q;
	logic                 qneg_q, rneg_q;
	logic [WORD_BITS:0]   trial;

	assign trial = {r_q, q_q[WORD_BITS-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(WORD_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= dividend[WORD_BITS-1] ? -dividend : dividend;
			d_q    <= divisor[WORD_BITS-1] ? -divisor : divisor;
			r_q    <= '0;
			qneg_q <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
			rneg_q <= dividend[WORD_BITS-1];
		end else if (cnt_q != '0) begin
			if (!trial[WORD_BITS]) begin
				r_q <= trial[WORD_BITS-1:0];
				q_q <= {q_q[WORD_BITS-2:0], 1'b1};
			end else begin
				r_q <= {r_q[WORD_BITS-2:0], q_q[WORD_BITS-1]};
				q_q <= {q_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy      = (cnt_q != '0);
	assign quotient  = qneg_q ? -q_q : q_q;
	assign remainder = rneg_q ? -r_q : r_q;
endmodule

// File: src/trse_datapath.sv
// Datapath: stack memory, pointer, operand registers, ALU and divider.
// Depends on trse_pkg and trse_div.
module trse_datapath #(
	parameter int STACK_DEPTH = trse_pkg::DefStackDepth,
	parameter int WORD_BITS   = trse_pkg::DefWordBits,
	localparam int PW = $clog2(STACK_DEPTH + 1),
	localparam int AW = $clog2(STACK_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  trse_pkg::trse_cmd_t   cmd,
	input  logic [4:0]            action,
	input  logic [WORD_BITS-1:0]  push_value,
	output trse_pkg::trse_sts_t   sts,
	output logic [4:0]            act_q,
	output logic [PW-1:0]         sp_q,
	output logic                  ta_q,
	output logic                  a_zero,
	output logic                  tb_q,
	output logic                  top_valid,
	output logic [WORD_BITS-1:0]  top_word,
	output logic                  top_is_bool,
	output logic [PW-1:0]         stack_depth
);
	logic [WORD_BITS:0]   mem [STACK_DEPTH];
	logic [WORD_BITS-1:0] pv_q, a_q, b_q, prod_q;
	logic [WORD_BITS:0]   rd_q;
	logic [WORD_BITS-1:0] quo, rem;
	logic                 div_busy;
	logic [WORD_BITS:0]   res;
	logic [WORD_BITS:0]   wdata;
	logic [AW-1:0]        waddr;
	logic                 we;
	logic [AW-1:0]        raddr;
	logic                 blt, alt, eqv;
	logic                 tv_q, tb_out_q;
	logic [WORD_BITS-1:0] tw_q;

	trse_div #(.WORD_BITS(WORD_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(b_q), .divisor(a_q), .busy(div_busy),
		.quotient(quo), .remainder(rem)
	);
	assign sts.div_busy = div_busy;

	assign blt = $signed(b_q) < $signed(a_q);
	assign alt = $signed(a_q) < $signed(b_q);
	assign eqv = (a_q == b_q);
	assign a_zero = (a_q == '0);

	always_comb begin
		res = '0;
		case (act_q)
			trse_pkg::ACT_PUSH_INT:  res = {1'b0, pv_q};
			trse_pkg::ACT_PUSH_BOOL: res = {1'b1, {(WORD_BITS-1){1'b0}}, pv_q[0]};
			trse_pkg::ACT_NOT:       res = {1'b1, {(WORD_BITS-1){1'b0}}, a_zero};
			trse_pkg::ACT_DUP, trse_pkg::ACT_SWAP: res = {ta_q, a_q};
			trse_pkg::ACT_ADD:       res = {1'b0, a_q + b_q};
			trse_pkg::ACT_SUB:       res = {1'b0, b_q - a_q};
			trse_pkg::ACT_MUL:       res = {1'b0, prod_q};
			trse_pkg::ACT_DIV:       res = {1'b0, quo};
			trse_pkg::ACT_MOD:       res = {1'b0, rem};
			trse_pkg::ACT_EQ:
				res = {1'b1, {(WORD_BITS-1){1'b0}}, (ta_q == tb_q) && eqv};
			trse_pkg::ACT_LT: res = {1'b1, {(WORD_BITS-1){1'b0}}, blt};
			trse_pkg::ACT_GT: res = {1'b1, {(WORD_BITS-1){1'b0}}, alt};
			trse_pkg::ACT_LE: res = {1'b1, {(WORD_BITS-1){1'b0}}, blt | eqv};
			trse_pkg::ACT_GE: res = {1'b1, {(WORD_BITS-1){1'b0}}, alt | eqv};
			default:          res = '0;
		endcase
	end

	// Single write port: swap writes A at sp-2 (sp already lowered by two, so at sp)
	// first, and B at sp+1 via the push path in the next cycle.
	always_comb begin
		we    = cmd.wr_push | cmd.wr_top | cmd.wr_swap;
		wdata = cmd.wr_swap ? {ta_q, a_q} : res;
		waddr = cmd.wr_top ? AW'(sp_q - 1'b1) : AW'(sp_q);
		if (cmd.rd_top | cmd.rd_next) raddr = AW'(sp_q - 2'd2);
		else                          raddr = AW'(sp_q - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) pv_q <= push_value;
		if (cmd.rd_top) begin
			a_q  <= rd_q[WORD_BITS-1:0];
			ta_q <= rd_q[WORD_BITS];
		end
		if (cmd.rd_next) begin
			b_q  <= rd_q[WORD_BITS-1:0];
			tb_q <= rd_q[WORD_BITS];
		end
		if (cmd.mul_cap) prod_q <= WORD_BITS'(a_q * b_q);
		if (cmd.wr_swap) begin
			a_q  <= b_q;
			ta_q <= tb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
			sp_q  <= '0;
			tv_q  <= 1'b0;
			tw_q  <= '0;
			tb_out_q <= 1'b0;
		end else begin
			if (cmd.latch_in) act_q <= action;
			if (cmd.clear)        sp_q <= '0;
			else if (cmd.pop_two) sp_q <= sp_q - PW'(2);
			else if (cmd.pop_one) sp_q <= sp_q - PW'(1);
			else if (cmd.wr_push | cmd.wr_swap) sp_q <= sp_q + PW'(1);
			if (cmd.done) begin
				tv_q     <= (sp_q != '0);
				tw_q     <= (sp_q != '0) ? rd_q[WORD_BITS-1:0] : '0;
				tb_out_q <= (sp_q != '0) ? rd_q[WORD_BITS] : 1'b0;
			end
		end
	end

	assign top_valid   = tv_q;
	assign top_word    = tw_q;
	assign top_is_bool = tb_out_q;
	assign stack_depth = sp_q;
endmodule

// File: src/trse_ctrl.sv
// Controller state machine sequencing reads, ALU ops, writes and the divider.
// Depends on trse_pkg.
module trse_ctrl #(
	parameter int STACK_DEPTH = trse_pkg::DefStackDepth,
	localparam int PW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output logic [2:0]          status,
	output trse_pkg::trse_cmd_t cmd,
	input  trse_pkg::trse_sts_t sts,
	input  logic [4:0]          act_q,
	input  logic [PW-1:0]       sp_q,
	input  logic                ta_q,
	input  logic                a_zero,
	input  logic                tb_q
);
	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_RDA, S_RDB, S_CAPB, S_EXEC, S_MUL, S_DIVW,
		S_SWAP2, S_RDOUT, S_OUT, S_DONE
	} state_t;

	state_t     state_q;
	logic [2:0] status_q;
	logic       binop;
	logic       full;
	logic       blocked;

	assign full  = (sp_q == PW'(STACK_DEPTH));
	assign binop = (act_q >= trse_pkg::ACT_SWAP) && (act_q <= trse_pkg::ACT_GE);
	// An integer zero on top stops div and mod before anything is popped.
	// The A register holds the top from the CAPB step on.
	assign blocked = (act_q == trse_pkg::ACT_DIV || act_q == trse_pkg::ACT_MOD)
		&& (sp_q != '0) && !ta_q && a_zero;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.latch_in = start;
			S_RDB:  cmd.rd_top = 1'b1;
			S_CAPB: begin
				if (!blocked && sp_q >= PW'(2)) begin
					cmd.rd_next = 1'b1;
					cmd.pop_two = 1'b1;
				end else if (!blocked && sp_q != '0) begin
					cmd.pop_one = 1'b1;
				end
			end
			S_EXEC: begin
				case (act_q)
					trse_pkg::ACT_PUSH_INT, trse_pkg::ACT_PUSH_BOOL:
						cmd.wr_push = !full;
					trse_pkg::ACT_NOT: cmd.wr_top = (sp_q != '0) && ta_q;
					trse_pkg::ACT_DUP: cmd.wr_push = (sp_q != '0) && !full;
					trse_pkg::ACT_DROP: cmd.pop_one = (sp_q != '0);
					trse_pkg::ACT_CLEAR: cmd.clear = 1'b1;
					trse_pkg::ACT_SWAP: cmd.wr_swap = 1'b1;
					trse_pkg::ACT_EQ: cmd.wr_push = 1'b1;
					trse_pkg::ACT_MUL: cmd.mul_cap = !(ta_q | tb_q);
					trse_pkg::ACT_DIV, trse_pkg::ACT_MOD:
						cmd.div_start = !(ta_q | tb_q);
					default: cmd.wr_push = binop && !(ta_q | tb_q);
				endcase
			end
			S_MUL:   cmd.wr_push = 1'b1;
			S_SWAP2: cmd.wr_push = 1'b1;
			S_DIVW:  cmd.wr_push = !sts.div_busy;
			S_OUT:   cmd.done = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= trse_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_DEC;
				S_DEC: begin
					status_q <= trse_pkg::ST_OK;
					state_q  <= S_RDA;
				end
				S_RDA: state_q <= S_RDB; // memory read of the top at sp-1
				S_RDB: begin
					// The A register loads at this edge; two-operand commands
					// check the stack in CAPB once the top is known.
					if (binop) state_q <= S_CAPB;
					else state_q <= S_EXEC;
				end
				S_CAPB: begin
					if (blocked) begin
						status_q <= trse_pkg::ST_DIV_ZERO;
						state_q  <= S_RDOUT;
					end else if (sp_q < PW'(2)) begin
						status_q <= trse_pkg::ST_EMPTY;
						state_q  <= S_RDOUT;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RDOUT;
					case (act_q)
						trse_pkg::ACT_PUSH_INT, trse_pkg::ACT_PUSH_BOOL,
						trse_pkg::ACT_DUP: begin
							if (act_q == trse_pkg::ACT_DUP && sp_q == '0)
								status_q <= trse_pkg::ST_EMPTY;
							else if (full) status_q <= trse_pkg::ST_FULL;
						end
						trse_pkg::ACT_NOT: begin
							if (sp_q == '0) status_q <= trse_pkg::ST_EMPTY;
							else if (!ta_q) status_q <= trse_pkg::ST_NOT_BOOL;
						end
						trse_pkg::ACT_DROP, trse_pkg::ACT_PRINT:
							if (sp_q == '0) status_q <= trse_pkg::ST_EMPTY;
						default: ;
					endcase
				end
				S_MUL:   state_q <= S_RDOUT;
				S_DIVW:  if (!sts.div_busy) state_q <= S_RDOUT;
				S_SWAP2: state_q <= S_RDOUT;
				S_RDOUT: state_q <= S_OUT;
				S_OUT:   state_q <= S_DONE;
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			// Binary operation overrides of the EXEC step.
			if (state_q == S_EXEC && binop) begin
				if (act_q == trse_pkg::ACT_SWAP) state_q <= S_SWAP2;
				else if (act_q != trse_pkg::ACT_EQ && (ta_q | tb_q))
					status_q <= trse_pkg::ST_NOT_INT;
				else if (act_q == trse_pkg::ACT_MUL) state_q <= S_MUL;
				else if (act_q == trse_pkg::ACT_DIV || act_q == trse_pkg::ACT_MOD)
					state_q <= S_DIVW;
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_DONE);
	assign status = status_q;
endmodule

// File: src/typed_rpn_stack_evaluator_core.sv
// Top level of the typed RPN stack evaluator.
// Depends on trse_pkg, trse_ctrl and trse_datapath (and trse_div below it).
//
// Usage: drive action and push_value with start high while busy is low; the
// command word is taken at that clock edge and busy rises the next cycle.
// Exactly one result word follows: status, top_valid, top_word, top_is_bool
// and stack_depth are valid for the single cycle in which done is high, and
// the receiver takes it then; it cannot stall the block.
// Sequence: every command steps through DEC, RDA and RDB after the accepting
// edge; two-operand commands then pass CAPB, and a short stack or a blocked
// divide goes from there straight to RDOUT. EXEC follows; mul and swap add MUL
// or SWAP2, and div and mod wait in DIVW on the one bit per cycle divider. All
// end in RDOUT, OUT and DONE. One command is in flight at a time and busy drops
// the cycle after done, so a new command is taken only once the last is through.
// The stack lives in a memory of STACK_DEPTH entries with one write port and
// one registered read port; each access step goes through that registered read.
// Reset clears the stack pointer and controller; memory contents are not
// cleared, as only entries below the pointer are ever used.
// A zero integer on top blocks div and mod before any pop.
module typed_rpn_stack_evaluator_core #(
	parameter int STACK_DEPTH = trse_pkg::DefStackDepth,
	parameter int WORD_BITS   = trse_pkg::DefWordBits,
	localparam int PW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  logic [4:0]           action,
	input  logic [WORD_BITS-1:0] push_value,
	output logic [2:0]           status,
	output logic                 top_valid,
	output logic [WORD_BITS-1:0] top_word,
	output logic                 top_is_bool,
	output logic [PW-1:0]        stack_depth
);
	trse_pkg::trse_cmd_t cmd;
	trse_pkg::trse_sts_t sts;
	logic [4:0]          act_q;
	logic [PW-1:0]       sp_q;
	logic                ta_q, tb_q, a_zero;

	// The controller sequences every command, including the divide-by-zero
	// check, which it makes once the top entry sits in the A register.
	trse_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.status(status), .cmd(cmd),
		.sts(sts), .act_q(act_q), .sp_q(sp_q),
		.ta_q(ta_q), .a_zero(a_zero), .tb_q(tb_q)
	);

	trse_datapath #(.STACK_DEPTH(STACK_DEPTH), .WORD_BITS(WORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .action(action),
		.push_value(push_value), .sts(sts), .act_q(act_q), .sp_q(sp_q),
		.ta_q(ta_q), .a_zero(a_zero), .tb_q(tb_q), .top_valid(top_valid),
		.top_word(top_word), .top_is_bool(top_is_bool), .stack_depth(stack_depth)
	);

`ifndef SYNTH
	// Busy drops right after the result word, so the next command can come.
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy held after done");
	// The depth never exceeds the store.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		stack_depth <= PW'(STACK_DEPTH)) else $error("depth overflow");
	// An empty stack shows no top entry.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && stack_depth == '0 |-> !top_valid && top_word == '0)
		else $error("top shown on empty stack");
`endif
endmodule
